/* sv/lip_ts_pkg.sv */
// Shared definitions for the LIP replacement priority keeper.
// Holds request kind codes, default sizes and the search control struct.
// No dependencies.
package lip_ts_pkg;

  localparam int NUM_SETS_DEF      = 64;
  localparam int NUM_WAYS_DEF      = 8;
  localparam int PRIORITY_BITS_DEF = 32;

  localparam int KIND_W     = 2;
  localparam int SET_IDX_W  = 6;
  localparam int WAY_IDX_W  = 3;

  localparam logic [KIND_W-1:0] KIND_INVALIDATE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TOUCH      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INSERT     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY      = 2'd3;

  typedef struct packed {
    logic step;
    logic first;
  } srch_ctl_t;

endpackage

/* sv/lip_ts_prio_mem.sv */
// Priority store: one entry per way of every set, one write and one read port.
// Read data is registered. Depends on lip_ts_pkg.
module lip_ts_prio_mem #(
  parameter int DEPTH  = lip_ts_pkg::NUM_SETS_DEF * lip_ts_pkg::NUM_WAYS_DEF,
  parameter int DATA_W = lip_ts_pkg::PRIORITY_BITS_DEF,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/lip_ts_search.sv */
// Shared compare unit for the victim search: keeps the lowest priority seen
// and its way, one way per step. Depends on lip_ts_pkg.
module lip_ts_search #(
  parameter int NUM_WAYS      = lip_ts_pkg::NUM_WAYS_DEF,
  parameter int PRIORITY_BITS = lip_ts_pkg::PRIORITY_BITS_DEF,
  localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1
) (
  input  logic                     clk,
  input  lip_ts_pkg::srch_ctl_t    ctl,
  input  logic [WAY_W-1:0]         way,
  input  logic [PRIORITY_BITS-1:0] prio,
  output logic [WAY_W-1:0]         best_way,
  output logic                     best_invalid
);

  localparam logic [PRIORITY_BITS-1:0] PRIO_INVALID = {1'b1, {(PRIORITY_BITS-1){1'b0}}};

  logic [PRIORITY_BITS-1:0] best_prio_r;
  logic [WAY_W-1:0]         best_way_r;
  logic                     take;

  assign take = ctl.step && (ctl.first || ($signed(prio) < $signed(best_prio_r)));

  always_ff @(posedge clk) begin
    if (take) begin
      best_prio_r <= prio;
      best_way_r  <= way;
    end
  end

  assign best_way     = best_way_r;
  assign best_invalid = (best_prio_r == PRIO_INVALID);

endmodule

/* sv/lip_timestamp_replacement.sv */
// LIP replacement priority keeper. After reset the block sweeps the priority store
// once, one entry a cycle, over all NUM_SETS*NUM_WAYS entries, and stalls input until done.
// Invalidate, touch and insert requests write the single store write port on the
// accepting edge. During a victim query the store's one read port delivers one way per
// cycle to a shared compare unit, then the QOUT state loads the result register once
// no held result blocks it. Depends on lip_ts_pkg, lip_ts_prio_mem, lip_ts_search.
module lip_timestamp_replacement #(
  parameter int NUM_SETS      = lip_ts_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS      = lip_ts_pkg::NUM_WAYS_DEF,
  parameter int PRIORITY_BITS = lip_ts_pkg::PRIORITY_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [lip_ts_pkg::KIND_W-1:0]    in_kind,
  input  logic [lip_ts_pkg::SET_IDX_W-1:0] in_set_index,
  input  logic [lip_ts_pkg::WAY_IDX_W-1:0] in_way_index,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [lip_ts_pkg::WAY_IDX_W-1:0] out_victim_way,
  output logic                             out_victim_was_invalid
);

  localparam int DEPTH  = NUM_SETS * NUM_WAYS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int WAYC_W = $clog2(NUM_WAYS + 1);
  localparam int CNT_W  = PRIORITY_BITS - 1;
  localparam logic [PRIORITY_BITS-1:0] PRIO_INVALID = {1'b1, {CNT_W{1'b0}}};

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_QRUN  = 3'd2;
  localparam logic [2:0] ST_QOUT  = 3'd3;

  logic [2:0]               state_r, state_nxt;
  logic [ADDR_W-1:0]        clr_addr_r, clr_addr_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt, cnt_inc;
  logic [ADDR_W-1:0]        base_r, base_nxt;
  logic [WAYC_W-1:0]        iss_way_r, iss_way_nxt;
  logic [WAY_W-1:0]         cmp_way_r;
  logic                     rd_vld_r;
  logic                     oor_r, oor_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [lip_ts_pkg::WAY_IDX_W-1:0] out_way_r, out_way_nxt;
  logic                     out_inv_r, out_inv_nxt;

  logic                     in_acc;
  logic                     in_range;
  logic                     mem_we, mem_re;
  logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
  logic [PRIORITY_BITS-1:0] mem_wdata, mem_rdata;
  lip_ts_pkg::srch_ctl_t    srch_ctl;
  logic [WAY_W-1:0]         best_way;
  logic                     best_invalid;
  logic                     last_cmp;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_range = (int'(in_set_index) < NUM_SETS) && (int'(in_way_index) < NUM_WAYS);
  assign cnt_inc  = (cnt_r == {CNT_W{1'b1}}) ? cnt_r : cnt_r + 1'b1;

  assign mem_re    = (state_r == ST_QRUN) && (int'(iss_way_r) < NUM_WAYS);
  assign mem_raddr = base_r + ADDR_W'(iss_way_r);
  assign last_cmp  = rd_vld_r && (cmp_way_r == WAY_W'(NUM_WAYS - 1));
  assign srch_ctl.step  = rd_vld_r;
  assign srch_ctl.first = (cmp_way_r == '0);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ADDR_W'(in_set_index) * ADDR_W'(NUM_WAYS) + ADDR_W'(in_way_index);
    mem_wdata = PRIO_INVALID;
    cnt_nxt   = cnt_r;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
    end else if (in_acc && in_range && (in_kind != lip_ts_pkg::KIND_QUERY)) begin
      mem_we = 1'b1;
      case (in_kind)
        lip_ts_pkg::KIND_TOUCH: begin
          mem_wdata = {1'b0, cnt_inc};
          cnt_nxt   = cnt_inc;
        end
        lip_ts_pkg::KIND_INSERT: begin
          mem_wdata = '0 - {1'b0, cnt_inc};
          cnt_nxt   = cnt_inc;
        end
        default: begin
          mem_wdata = PRIO_INVALID;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    base_nxt      = base_r;
    iss_way_nxt   = iss_way_r;
    oor_nxt       = oor_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_way_nxt   = out_way_r;
    out_inv_nxt   = out_inv_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && (in_kind == lip_ts_pkg::KIND_QUERY)) begin
          base_nxt    = ADDR_W'(in_set_index) * ADDR_W'(NUM_WAYS);
          iss_way_nxt = '0;
          if (int'(in_set_index) < NUM_SETS) begin
            oor_nxt   = 1'b0;
            state_nxt = ST_QRUN;
          end else begin
            oor_nxt   = 1'b1;
            state_nxt = ST_QOUT;
          end
        end
      end
      ST_QRUN: begin
        if (mem_re) begin
          iss_way_nxt = iss_way_r + 1'b1;
        end
        if (last_cmp) begin
          state_nxt = ST_QOUT;
        end
      end
      ST_QOUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_way_nxt   = oor_r ? '0 : lip_ts_pkg::WAY_IDX_W'(best_way);
          out_inv_nxt   = oor_r ? 1'b0 : best_invalid;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= mem_re;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r    <= base_nxt;
    iss_way_r <= iss_way_nxt;
    cmp_way_r <= WAY_W'(iss_way_r);
    oor_r     <= oor_nxt;
    out_way_r <= out_way_nxt;
    out_inv_r <= out_inv_nxt;
  end

  lip_ts_prio_mem #(
    .DEPTH  (DEPTH),
    .DATA_W (PRIORITY_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lip_ts_search #(
    .NUM_WAYS      (NUM_WAYS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_search (
    .clk          (clk),
    .ctl          (srch_ctl),
    .way          (cmp_way_r),
    .prio         (mem_rdata),
    .best_way     (best_way),
    .best_invalid (best_invalid)
  );

  assign out_valid              = out_valid_r;
  assign out_victim_way         = out_way_r;
  assign out_victim_was_invalid = out_inv_r;

  a_result_from_qout: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_QOUT))
    else $error("result appeared without a finished query");

  a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QRUN) |-> !mem_we)
    else $error("priority store written during victim search");

  a_counter_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r >= $past(cnt_r)))
    else $error("age counter moved backward");

endmodule
